[sv/scha_pkg.sv]
// Shared types, constants and helpers for the size-class heap allocator.
package scha_pkg;

  localparam int ADDR_BITS_DEF  = 14;
  localparam int CLASS_COUNT    = 16;
  localparam int BKT_W          = 4;
  localparam int CLS_W          = 8;
  localparam int LEN_W          = 11;
  localparam int HDR_BYTES      = 2;
  localparam int HEAP_BEGIN_RST = 2;
  localparam int QUEUE_DEPTH    = 2;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 32;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(1024);

  // register index, taken from byte address bit 2
  localparam logic REG_HEAP_BEGIN = 1'b0;
  localparam logic REG_HEAP_END   = 1'b1;

  localparam logic [LEN_W-1:0] CLASS_CAP [CLASS_COUNT] = '{
    LEN_W'(4),   LEN_W'(8),   LEN_W'(12),  LEN_W'(16),
    LEN_W'(24),  LEN_W'(32),  LEN_W'(48),  LEN_W'(64),
    LEN_W'(96),  LEN_W'(128), LEN_W'(192), LEN_W'(256),
    LEN_W'(384), LEN_W'(512), LEN_W'(768), LEN_W'(1024)
  };

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_OOM        = 2'd1,
    ST_TOO_BIG    = 2'd2,
    ST_ZERO_CLASS = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_REJECT
  } op_t;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } bk_state_t;

  // classified request control, passed front to back through the queue
  typedef struct packed {
    op_t              op;
    status_t          status;
    logic [BKT_W-1:0] bucket;
  } scha_ctl_t;

  // first class whose capacity holds len
  function automatic logic [BKT_W-1:0] class_of_length(input logic [LEN_W-1:0] len);
    logic [BKT_W-1:0] b;
    b = '0;
    for (int i = CLASS_COUNT - 1; i >= 0; i--) begin
      if (len <= CLASS_CAP[i]) begin
        b = BKT_W'(i);
      end
    end
    return b;
  endfunction

  // capacity plus header bytes
  function automatic logic [LEN_W-1:0] chunk_size(input logic [BKT_W-1:0] b);
    return CLASS_CAP[b] + LEN_W'(HDR_BYTES);
  endfunction

endpackage

[sv/size_class_heap_allocator.sv]
// Top level of the size-class heap allocator: config registers, front end, queue, engine.
//
// Allocate and free requests enter one per cycle into a two-word queue while it has room;
// the engine behind it takes one request at a time, first popping it and reading header memory,
// then doing the write-back and registering the result, which waits while rsp_stall holds the
// previous result word. While a result waits, the engine can still take the next request from
// the queue and read its header, but it finishes that request only once the waiting result
// word is taken. Header memory holds one entry per even byte address and is not cleared, so
// a header read is only meaningful where an earlier allocation or free wrote it.
// Program heap_begin and heap_end only while no request is outstanding; writing heap_begin
// also restarts the bump pointer there.
module size_class_heap_allocator #(
  parameter int ADDR_BITS = scha_pkg::ADDR_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [scha_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [scha_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [scha_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic                            kind,
  input  logic [scha_pkg::LEN_W-1:0]      request_length,
  input  logic [scha_pkg::CLS_W-1:0]      object_class,
  input  logic [ADDR_BITS-1:0]            object_address,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic [1:0]                      status,
  output logic [ADDR_BITS-1:0]            granted_address,
  output logic [scha_pkg::BKT_W-1:0]      size_class
);
  import scha_pkg::*;

  localparam int Q_W = $bits(scha_ctl_t) + CLS_W + ADDR_BITS;

  logic [ADDR_BITS-1:0] heap_begin;
  logic [ADDR_BITS-1:0] heap_end;
  logic                 cfg_wr;
  logic                 begin_load;
  logic [ADDR_BITS-1:0] begin_value;

  logic                 q_full;
  logic                 q_push;
  logic                 q_valid;
  logic                 q_pop;
  scha_ctl_t            ent_ctl;
  logic [CLS_W-1:0]     ent_cls;
  logic [ADDR_BITS-1:0] ent_hdr;
  logic [Q_W-1:0]       q_wdata;
  logic [Q_W-1:0]       q_rdata;
  scha_ctl_t            q_ctl;
  logic [CLS_W-1:0]     q_cls;
  logic [ADDR_BITS-1:0] q_hdr;

  assign pready      = 1'b1;
  assign cfg_wr      = psel && penable && pwrite && pready;
  assign begin_load  = cfg_wr && (paddr[2] == REG_HEAP_BEGIN);
  assign begin_value = {pwdata[ADDR_BITS-1:1], 1'b0};
  assign prdata      = (paddr[2] == REG_HEAP_END) ? CFG_DATA_W'(heap_end)
                                                  : CFG_DATA_W'(heap_begin);

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_begin <= ADDR_BITS'(HEAP_BEGIN_RST);
      heap_end   <= '1;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_HEAP_BEGIN) begin
        heap_begin <= begin_value;
      end else begin
        heap_end <= pwdata[ADDR_BITS-1:0];
      end
    end
  end

  scha_front #(.ADDR_BITS(ADDR_BITS)) u_front (
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .kind           (kind),
    .request_length (request_length),
    .object_class   (object_class),
    .object_address (object_address),
    .q_full         (q_full),
    .push           (q_push),
    .ent_ctl        (ent_ctl),
    .ent_cls        (ent_cls),
    .ent_hdr        (ent_hdr)
  );

  assign q_wdata = {ent_ctl, ent_cls, ent_hdr};
  assign {q_ctl, q_cls, q_hdr} = q_rdata;

  scha_fifo #(.WIDTH(Q_W)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .valid (q_valid),
    .pop   (q_pop),
    .rdata (q_rdata)
  );

  scha_back #(.ADDR_BITS(ADDR_BITS)) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .pop             (q_pop),
    .q_ctl           (q_ctl),
    .q_cls           (q_cls),
    .q_hdr           (q_hdr),
    .heap_end        (heap_end),
    .begin_load      (begin_load),
    .begin_value     (begin_value),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .status          (status),
    .granted_address (granted_address),
    .size_class      (size_class)
  );

endmodule

[sv/scha_front.sv]
// Request front end: classifies each request word and pushes it to the queue.
module scha_front #(
  parameter int ADDR_BITS = scha_pkg::ADDR_BITS_DEF
) (
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic                          kind,
  input  logic [scha_pkg::LEN_W-1:0]    request_length,
  input  logic [scha_pkg::CLS_W-1:0]    object_class,
  input  logic [ADDR_BITS-1:0]          object_address,
  input  logic                          q_full,
  output logic                          push,
  output scha_pkg::scha_ctl_t           ent_ctl,
  output logic [scha_pkg::CLS_W-1:0]    ent_cls,
  output logic [ADDR_BITS-1:0]          ent_hdr
);
  import scha_pkg::*;

  logic [ADDR_BITS-1:0] hdr_sub;

  assign req_stall = q_full;
  assign push      = req_valid && !q_full;

  // header sits two bytes below the object, always even
  assign hdr_sub = object_address - ADDR_BITS'(HDR_BYTES);
  assign ent_hdr = {hdr_sub[ADDR_BITS-1:1], 1'b0};
  assign ent_cls = object_class;

  always_comb begin
    ent_ctl.op     = OP_ALLOC;
    ent_ctl.status = ST_OK;
    ent_ctl.bucket = class_of_length(request_length);
    priority if (kind) begin
      ent_ctl.op     = OP_FREE;
      ent_ctl.bucket = '0;
    end else if (object_class == '0) begin
      ent_ctl.op     = OP_REJECT;
      ent_ctl.status = ST_ZERO_CLASS;
      ent_ctl.bucket = '0;
    end else if (request_length > MAX_LEN) begin
      ent_ctl.op     = OP_REJECT;
      ent_ctl.status = ST_TOO_BIG;
      ent_ctl.bucket = '0;
    end else begin
      ent_ctl.op     = OP_ALLOC;
    end
  end

endmodule

[sv/scha_fifo.sv]
// Small word queue between the front end and the allocation engine.
module scha_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  output logic             valid,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata
);
  import scha_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wdata;
    end
  end

endmodule

[sv/scha_back.sv]
// Allocation engine: header memory, free-list heads, bump pointer, result register.
module scha_back #(
  parameter int ADDR_BITS = scha_pkg::ADDR_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          pop,
  input  scha_pkg::scha_ctl_t           q_ctl,
  input  logic [scha_pkg::CLS_W-1:0]    q_cls,
  input  logic [ADDR_BITS-1:0]          q_hdr,
  input  logic [ADDR_BITS-1:0]          heap_end,
  input  logic                          begin_load,
  input  logic [ADDR_BITS-1:0]          begin_value,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [1:0]                    status,
  output logic [ADDR_BITS-1:0]          granted_address,
  output logic [scha_pkg::BKT_W-1:0]    size_class
);
  import scha_pkg::*;

  localparam int IDX_W     = ADDR_BITS - 1;
  localparam int HDR_DEPTH = 2 ** IDX_W;
  localparam int HDR_W     = BKT_W + CLS_W + ADDR_BITS;

  bk_state_t state, state_next;

  scha_ctl_t            cur_ctl;
  logic [CLS_W-1:0]     cur_cls;
  logic [ADDR_BITS-1:0] cur_hdr;
  logic [ADDR_BITS-1:0] cur_head;

  logic [ADDR_BITS-1:0] heads [CLASS_COUNT];
  logic [ADDR_BITS-1:0] bump;

  // header entry: {bucket, class, next}
  logic [HDR_W-1:0] hdr_mem [HDR_DEPTH];
  logic [HDR_W-1:0] rd_data;
  logic [IDX_W-1:0] rd_idx;
  logic [BKT_W-1:0] rd_bkt;
  logic [ADDR_BITS-1:0] rd_next;

  logic [BKT_W-1:0]     head_sel;
  logic [ADDR_BITS-1:0] head_val;
  logic [ADDR_BITS:0]   bump_sum;

  logic                 exec_go;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_idx;
  logic [HDR_W-1:0]     wr_data;
  logic                 head_wr;
  logic [BKT_W-1:0]     head_wr_bkt;
  logic [ADDR_BITS-1:0] head_wr_val;
  logic                 bump_wr;
  status_t              res_status;
  logic [ADDR_BITS-1:0] res_addr;
  logic [BKT_W-1:0]     res_bkt;

  assign rd_bkt  = rd_data[HDR_W-1 -: BKT_W];
  assign rd_next = rd_data[ADDR_BITS-1:0];

  // one head read port: queue bucket at pop, header bucket during execute
  assign head_sel = (state == BK_EXEC) ? rd_bkt : q_ctl.bucket;
  assign head_val = heads[head_sel];

  assign rd_idx = (q_ctl.op == OP_FREE) ? q_hdr[ADDR_BITS-1:1] : head_val[ADDR_BITS-1:1];

  assign bump_sum = {1'b0, bump} + (ADDR_BITS + 1)'(chunk_size(cur_ctl.bucket));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (q_valid) state_next = BK_EXEC;
      BK_EXEC: if (!rsp_valid || !rsp_stall) state_next = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop     = (state == BK_IDLE) && q_valid;
    exec_go = (state == BK_EXEC) && (!rsp_valid || !rsp_stall);

    wr_en       = 1'b0;
    wr_idx      = cur_hdr[ADDR_BITS-1:1];
    wr_data     = '0;
    head_wr     = 1'b0;
    head_wr_bkt = cur_ctl.bucket;
    head_wr_val = '0;
    bump_wr     = 1'b0;
    res_status  = cur_ctl.status;
    res_addr    = '0;
    res_bkt     = '0;

    unique case (cur_ctl.op)
      OP_FREE: begin
        res_status  = ST_OK;
        res_bkt     = rd_bkt;
        wr_en       = exec_go;
        wr_data     = {rd_bkt, CLS_W'(0), head_val};
        head_wr     = exec_go;
        head_wr_bkt = rd_bkt;
        head_wr_val = cur_hdr;
      end
      OP_ALLOC: begin
        res_bkt = cur_ctl.bucket;
        if (cur_head != '0) begin
          wr_en       = exec_go;
          wr_idx      = cur_head[ADDR_BITS-1:1];
          wr_data     = {rd_bkt, cur_cls, rd_next};
          head_wr     = exec_go;
          head_wr_val = rd_next;
          res_addr    = cur_head + ADDR_BITS'(HDR_BYTES);
        end else if (bump_sum >= {1'b0, heap_end}) begin
          res_status = ST_OOM;
        end else begin
          wr_en    = exec_go;
          wr_idx   = bump[ADDR_BITS-1:1];
          wr_data  = {cur_ctl.bucket, cur_cls, ADDR_BITS'(0)};
          bump_wr  = exec_go;
          res_addr = bump + ADDR_BITS'(HDR_BYTES);
        end
      end
      default: begin
        res_status = cur_ctl.status;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_ctl  <= q_ctl;
      cur_cls  <= q_cls;
      cur_hdr  <= q_hdr;
      cur_head <= head_val;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hdr_mem[wr_idx] <= wr_data;
    end
    if (pop) begin
      rd_data <= hdr_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CLASS_COUNT; i++) begin
        heads[i] <= '0;
      end
    end else if (head_wr) begin
      heads[head_wr_bkt] <= head_wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bump <= ADDR_BITS'(HEAP_BEGIN_RST);
    end else if (begin_load) begin
      bump <= begin_value;
    end else if (bump_wr) begin
      bump <= bump_sum[ADDR_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (exec_go) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      status          <= res_status;
      granted_address <= res_addr;
      size_class      <= res_bkt;
    end
  end

endmodule

[sv/scha_check.sv]
// Port-level checks on the allocator's result channel, bound to the top level.
module scha_check #(
  parameter int ADDR_BITS = scha_pkg::ADDR_BITS_DEF
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       rsp_valid,
  input logic                       rsp_stall,
  input logic [1:0]                 status,
  input logic [ADDR_BITS-1:0]       granted_address,
  input logic [scha_pkg::BKT_W-1:0] size_class
);
  import scha_pkg::*;

  // a held result word stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("result word dropped while stalled");

  // no result word straight after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

  // only a successful allocate hands out an address
  a_fail_addr: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != ST_OK) |-> granted_address == '0)
    else $error("address given with error status");

  // rejected requests carry class zero
  a_reject_cls: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_TOO_BIG || status == ST_ZERO_CLASS) |-> size_class == '0)
    else $error("size class on rejected request");

endmodule

bind size_class_heap_allocator scha_check #(.ADDR_BITS(ADDR_BITS)) u_scha_check (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp_valid),
  .rsp_stall       (rsp_stall),
  .status          (status),
  .granted_address (granted_address),
  .size_class      (size_class)
);
